[rtl/core/lz4d_pkg.sv]
// Shared types, codes and constants of the LZ4 block decompressor.
package lz4d_pkg;

   localparam int WINDOW_DEPTH_DEF = 65536;
   localparam int QUEUE_DEPTH      = 3;

   localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
   localparam logic [3:0]  NIBBLE_MAX  = 4'hF;
   localparam logic [7:0]  EXT_MORE    = 8'hFF;
   localparam logic [31:0] MATCH_EXT0  = 32'd15;
   localparam logic [8:0]  MIN_MATCH   = 9'd4;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_TRUNC  = 3'd1;
   localparam logic [2:0] ERR_OVER   = 3'd2;
   localparam logic [2:0] ERR_OFFSET = 3'd3;
   localparam logic [2:0] ERR_LENGTH = 3'd4;
   localparam logic [2:0] ERR_PUSH   = 3'd5;

   localparam logic [1:0] ST_BUSY   = 2'd0;
   localparam logic [1:0] ST_DONE   = 2'd1;
   localparam logic [1:0] ST_FAILED = 2'd2;

   typedef enum logic [2:0] {
      PH_TOKEN  = 3'd0,
      PH_LITEXT = 3'd1,
      PH_LIT    = 3'd2,
      PH_OFFLO  = 3'd3,
      PH_OFFHI  = 3'd4,
      PH_MEXT   = 3'd5,
      PH_COPY   = 3'd6,
      PH_IDLE   = 3'd7
   } phase_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       copy_pending;
      logic [1:0] status;
      logic [2:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      logic    copy;
      logic    fwd;
      rsp_type rsp;
   } stage_type;

   // Saturating add of a narrow increment to a 32-bit length.
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [8:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {24'd0, b};
      return s[32] ? SAT32 : s[31:0];
   endfunction

   // True when len more bytes would pass the expected block length.
   function automatic logic overflows(input logic [31:0] len, input logic [31:0] produced,
                                      input logic [31:0] expected);
      return (len == SAT32) || (({1'b0, produced} + {1'b0, len}) > {1'b0, expected});
   endfunction

endpackage

[rtl/core/lz4d_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lz4d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lz4d_ctrl.sv]
// Sequence decoder: token, length, offset and copy state of the current block.
module lz4d_ctrl #(
   parameter int WINDOW_DEPTH = lz4d_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            action,
   input  logic [7:0]                      in_byte,
   input  logic                            last_byte,
   input  logic                            csr_wr_en,
   input  logic [31:0]                     csr_wr_data,
   output lz4d_pkg::stage_type             s0,
   output logic [$clog2(WINDOW_DEPTH)-1:0] pos,
   output logic [$clog2(WINDOW_DEPTH)-1:0] src
);
   import lz4d_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);

   phase_type   phase_ff, phase_in;
   logic [3:0]  nib_ff, nib_in;
   logic [31:0] lit_ff, lit_in;
   logic [31:0] mat_ff, mat_in;
   logic [15:0] off_ff, off_in;
   logic [31:0] bp_ff, bp_in;
   logic        ended_ff, ended_in;
   logic [2:0]  fail_ff, fail_in;
   logic [31:0] exp_ff;
   logic [31:0] back;

   logic        fail_req;
   logic [2:0]  fail_code;
   logic        finish_req;
   logic        emit;
   logic        is_copy;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TOKEN;
         nib_ff   <= '0;
         lit_ff   <= '0;
         mat_ff   <= '0;
         off_ff   <= '0;
         bp_ff    <= '0;
         ended_ff <= 1'b0;
         fail_ff  <= ERR_NONE;
         exp_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         nib_ff   <= nib_in;
         lit_ff   <= lit_in;
         mat_ff   <= mat_in;
         off_ff   <= off_in;
         bp_ff    <= bp_in;
         ended_ff <= ended_in;
         fail_ff  <= fail_in;
         if (csr_wr_en) begin
            exp_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      nib_in     = nib_ff;
      lit_in     = lit_ff;
      mat_in     = mat_ff;
      off_in     = off_ff;
      bp_in      = bp_ff;
      ended_in   = ended_ff;
      fail_in    = fail_ff;
      fail_req   = 1'b0;
      fail_code  = ERR_NONE;
      finish_req = 1'b0;
      emit       = 1'b0;
      is_copy    = 1'b0;

      if (accept) begin
         if (action == ACT_PULL) begin
            if (phase_ff == PH_COPY) begin
               emit    = 1'b1;
               is_copy = 1'b1;
               bp_in   = bp_ff + 32'd1;
               mat_in  = mat_ff - 32'd1;
               if (mat_in == '0) begin
                  if (ended_ff) begin
                     finish_req = 1'b1;
                  end else begin
                     phase_in = PH_TOKEN;
                  end
               end
            end
         end else if (phase_ff == PH_COPY) begin
            fail_req  = 1'b1;
            fail_code = ERR_PUSH;
         end else if (phase_ff == PH_IDLE && fail_ff != ERR_NONE && !ended_ff) begin
            // Remaining bytes of a failed block are swallowed.
            if (last_byte) begin
               ended_in = 1'b1;
            end
         end else begin
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_TOKEN;
               nib_in   = '0;
               lit_in   = '0;
               mat_in   = '0;
               off_in   = '0;
               bp_in    = '0;
               ended_in = 1'b0;
               fail_in  = ERR_NONE;
            end
            case (phase_in)
               PH_TOKEN: begin
                  lit_in = {28'd0, in_byte[7:4]};
                  nib_in = in_byte[3:0];
                  if (in_byte[7:4] == NIBBLE_MAX) begin
                     if (last_byte) begin
                        fail_req  = 1'b1;
                        fail_code = ERR_TRUNC;
                     end else begin
                        phase_in = PH_LITEXT;
                     end
                  end else if (in_byte[7:4] == 4'd0) begin
                     if (last_byte) begin
                        finish_req = 1'b1;
                     end else begin
                        phase_in = PH_OFFLO;
                     end
                  end else if (last_byte) begin
                     fail_req  = 1'b1;
                     fail_code = ERR_TRUNC;
                  end else if (overflows(lit_in, bp_in, exp_ff)) begin
                     fail_req  = 1'b1;
                     fail_code = ERR_OVER;
                  end else begin
                     phase_in = PH_LIT;
                  end
               end
               PH_LITEXT: begin
                  lit_in = sat_add(lit_in, {1'b0, in_byte});
                  if (in_byte == EXT_MORE) begin
                     if (last_byte) begin
                        fail_req  = 1'b1;
                        fail_code = ERR_TRUNC;
                     end
                  end else if (last_byte) begin
                     fail_req  = 1'b1;
                     fail_code = ERR_TRUNC;
                  end else if (overflows(lit_in, bp_in, exp_ff)) begin
                     fail_req  = 1'b1;
                     fail_code = ERR_OVER;
                  end else begin
                     phase_in = PH_LIT;
                  end
               end
               PH_LIT: begin
                  emit   = 1'b1;
                  bp_in  = bp_ff + 32'd1;
                  lit_in = lit_ff - 32'd1;
                  if (lit_in == '0) begin
                     if (last_byte) begin
                        finish_req = 1'b1;
                     end else begin
                        phase_in = PH_OFFLO;
                     end
                  end else if (last_byte) begin
                     fail_req  = 1'b1;
                     fail_code = ERR_TRUNC;
                  end
               end
               PH_OFFLO: begin
                  off_in = {8'd0, in_byte};
                  if (last_byte) begin
                     fail_req  = 1'b1;
                     fail_code = ERR_TRUNC;
                  end else begin
                     phase_in = PH_OFFHI;
                  end
               end
               PH_OFFHI: begin
                  off_in = {in_byte, off_ff[7:0]};
                  if (off_in == '0 || {16'd0, off_in} > bp_ff) begin
                     fail_req  = 1'b1;
                     fail_code = ERR_OFFSET;
                  end else if (nib_ff == NIBBLE_MAX) begin
                     mat_in = MATCH_EXT0;
                     if (last_byte) begin
                        fail_req  = 1'b1;
                        fail_code = ERR_TRUNC;
                     end else begin
                        phase_in = PH_MEXT;
                     end
                  end else begin
                     mat_in = {28'd0, nib_ff} + 32'd4;
                     if (overflows(mat_in, bp_ff, exp_ff)) begin
                        fail_req  = 1'b1;
                        fail_code = ERR_OVER;
                     end else begin
                        if (last_byte) begin
                           ended_in = 1'b1;
                        end
                        phase_in = PH_COPY;
                     end
                  end
               end
               PH_MEXT: begin
                  if (in_byte == EXT_MORE) begin
                     mat_in = sat_add(mat_ff, {1'b0, in_byte});
                     if (last_byte) begin
                        fail_req  = 1'b1;
                        fail_code = ERR_TRUNC;
                     end
                  end else begin
                     // Extension byte and the minimum match length in one add.
                     mat_in = sat_add(mat_ff, {1'b0, in_byte} + MIN_MATCH);
                     if (overflows(mat_in, bp_ff, exp_ff)) begin
                        fail_req  = 1'b1;
                        fail_code = ERR_OVER;
                     end else begin
                        if (last_byte) begin
                           ended_in = 1'b1;
                        end
                        phase_in = PH_COPY;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         if (fail_req) begin
            fail_in  = fail_code;
            phase_in = PH_IDLE;
            lit_in   = '0;
            mat_in   = '0;
            if (last_byte) begin
               ended_in = 1'b1;
            end
         end
         if (finish_req) begin
            ended_in = 1'b1;
            phase_in = PH_IDLE;
            if (bp_in != exp_ff) begin
               fail_in = ERR_LENGTH;
            end
         end
      end
   end

   assign back = bp_ff - {16'd0, off_ff};
   assign pos  = bp_ff[AW-1:0];
   assign src  = back[AW-1:0];

   always_comb begin
      s0.valid            = accept;
      s0.copy             = is_copy;
      s0.fwd              = 1'b0;
      s0.rsp.out_valid    = emit;
      s0.rsp.out_byte     = (emit && !is_copy) ? in_byte : 8'd0;
      s0.rsp.copy_pending = (phase_in == PH_COPY);
      s0.rsp.status       = (fail_in != ERR_NONE) ? ST_FAILED :
                            ((phase_in == PH_IDLE) ? ST_DONE : ST_BUSY);
      s0.rsp.error_code   = fail_in;
   end

endmodule

[rtl/core/lz4d_outq.sv]
// Small result queue that decouples the decoder from the result channel.
module lz4d_outq (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          push,
   input  lz4d_pkg::rsp_type                             push_data,
   input  logic                                          pop,
   output logic                                          not_empty,
   output lz4d_pkg::rsp_type                             head_data,
   output logic [$clog2(lz4d_pkg::QUEUE_DEPTH+1)-1:0]    count
);
   import lz4d_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

   rsp_type       q_ff [QUEUE_DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PW'(1);
      end
      if (pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         q_ff[tail_ff] <= push_data;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign head_data = q_ff[head_ff];
   assign count     = cnt_ff;

endmodule

[rtl/core/lz4_block_decompressor_unit.sv]
// Top level of the LZ4 raw block decompressor with its 64 KiB history RAM.
//
//   Channel  Direction  Handshake             Word contents
//   req      in         req_valid/req_ready   action, in_byte, last_byte
//   rsp      out        rsp_valid/rsp_ready   out_valid, out_byte, copy_pending,
//                                             status, error_code
//   csr      in         csr_wr_en             expected_length (32 bits)
//
// One word is accepted per cycle while the result queue has room, pushes and pulls
// alike, and every accepted word gives one result word (decode stage, then history read stage).
// The pace is set by the single-read history RAM: a pull reads its source byte in
// the decode cycle and the registered data comes back in the next cycle, where it
// is also written to its own position. A read that hits the byte being written in
// that same cycle (offset of one) takes the byte that stage one writes instead.
// A three-word result queue keeps req_ready free of rsp_ready, so a stalled result
// side holds up to three words before input is held off. Reset is synchronous and
// clears all control state; the history RAM has no clearing pass since a block only
// reads positions it has already written.
module lz4_block_decompressor_unit #(
   parameter int WINDOW_DEPTH = lz4d_pkg::WINDOW_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_copy_pending,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import lz4d_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic          accept;
   stage_type     s0;
   stage_type     s1_ff, s1_in;
   logic [AW-1:0] pos;
   logic [AW-1:0] src;
   logic [AW-1:0] pos1_ff;
   logic [7:0]    ram_rd;
   logic [7:0]    s1_byte;
   rsp_type       s1_rsp;
   rsp_type       head;
   logic          q_not_empty;
   logic [CW-1:0] q_count;
   logic [CW:0]   in_flight;

   // Input is taken only while the queue can absorb every word already in flight.
   assign in_flight = {1'b0, q_count} + {{CW{1'b0}}, s1_ff.valid};
   assign req_ready = !reset && (in_flight < (CW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;

   lz4d_ctrl #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .in_byte     (req_in_byte),
      .last_byte   (req_last_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .s0          (s0),
      .pos         (pos),
      .src         (src)
   );

   // The byte a stage-one word carries: RAM data for a copy unless it was forwarded.
   assign s1_byte = (s1_ff.copy && !s1_ff.fwd) ? ram_rd : s1_ff.rsp.out_byte;

   always_comb begin
      s1_in = s0;
      if (s0.copy && s1_ff.valid && s1_ff.rsp.out_valid && (pos1_ff == src)) begin
         s1_in.fwd          = 1'b1;
         s1_in.rsp.out_byte = s1_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
      end
      pos1_ff <= pos;
   end

   lz4d_ram #(
      .WIDTH(8),
      .DEPTH(WINDOW_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (s1_ff.valid && s1_ff.rsp.out_valid),
      .wr_addr (pos1_ff),
      .wr_data (s1_byte),
      .rd_en   (s0.copy),
      .rd_addr (src),
      .rd_data (ram_rd)
   );

   always_comb begin
      s1_rsp          = s1_ff.rsp;
      s1_rsp.out_byte = s1_byte;
   end

   lz4d_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_ff.valid),
      .push_data (s1_rsp),
      .pop       (rsp_valid && rsp_ready),
      .not_empty (q_not_empty),
      .head_data (head),
      .count     (q_count)
   );

   assign rsp_valid        = q_not_empty;
   assign rsp_out_valid    = head.out_valid;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_copy_pending = head.copy_pending;
   assign rsp_status       = head.status;
   assign rsp_error_code   = head.error_code;

endmodule

[rtl/core/lz4d_checker.sv]
// Port-level checker for the decompressor and its bind to the top level.
module lz4d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_out_valid,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_copy_pending,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_error_code
);
   import lz4d_pkg::*;

   // A word without a decompressed byte carries a zero byte.
   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == 8'd0)
      else $error("result word without a byte carries a nonzero byte");

   // Failed status and a nonzero error code always go together.
   a_status_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_FAILED) == (rsp_error_code != ERR_NONE)))
      else $error("status and error code disagree");

   // A pending copy belongs to a block that is still busy.
   a_copy_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_copy_pending |-> rsp_status == ST_BUSY)
      else $error("copy pending outside a busy block");

   // A stalled result word holds its byte.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result word changed");

endmodule

bind lz4_block_decompressor_unit lz4d_checker u_lz4d_checker (.*);
